// ----- sv/chfa_pkg.sv -----
// shared types, constants and tables for the compass heading block
package chfa_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int MAX_CORDIC_STEPS = 24;

    localparam int FIELD_W     = 16;
    localparam int VAL_W       = FIELD_W + 1;
    localparam int PRESCALE_SH = 16;
    localparam int XY_W        = VAL_W + PRESCALE_SH + 2;
    localparam int ANG_W       = 32;
    localparam int HEAD_W      = 15;
    localparam int DECL_W      = 15;
    localparam int ROLE_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int FULL_TURN    = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int DECL_RESET   = 479;

    // axis role codes, the two codes above down mean ignored as well
    localparam logic [ROLE_W-1:0] ROLE_NORTH = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SOUTH = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_WEST  = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_EAST  = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_UP    = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_DOWN  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ROLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ROLE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ROLE      = 2'd3;

    typedef logic signed [FIELD_W-1:0] t_sample;
    typedef logic signed [VAL_W-1:0]   t_val;
    typedef logic signed [XY_W-1:0]    t_xy;
    typedef logic [ANG_W-1:0]          t_ang;
    typedef logic [HEAD_W-1:0]         t_heading;
    typedef logic signed [DECL_W-1:0]  t_decl;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    typedef struct packed {
        logic [ROLE_W-1:0] x;
        logic [ROLE_W-1:0] y;
        logic [ROLE_W-1:0] z;
    } t_roles;

    typedef struct packed {
        t_val north;
        t_val west;
        logic fault;
    } t_axes;

    // atan(2^-i) in binary angle, 2^32 per turn
    localparam logic [ANG_W-1:0] ATAN_TAB [MAX_CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

endpackage

// ----- sv/chfa_if.sv -----
// handshake channels for samples, headings and register writes
interface chfa_in_if;
    import chfa_pkg::*;
    logic    valid;
    logic    ready;
    t_sample field_x;
    t_sample field_y;
    t_sample field_z;
    modport source(output valid, output field_x, output field_y, output field_z,
                   input ready);
    modport sink(input valid, input field_x, input field_y, input field_z,
                 output ready);
endinterface

interface chfa_out_if;
    import chfa_pkg::*;
    logic     valid;
    logic     ready;
    t_heading heading;
    logic     orientation_fault;
    modport source(output valid, output heading, output orientation_fault,
                   input ready);
    modport sink(input valid, input heading, input orientation_fault,
                 output ready);
endinterface

interface chfa_cfg_if;
    import chfa_pkg::*;
    logic                valid;
    logic                ready;
    t_cfg_idx            index;
    logic [DECL_W-1:0]   data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- sv/chfa_fifo.sv -----
// short queue between the axis classifier and the cordic pipeline
module chfa_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  chfa_pkg::t_axes i_push_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output chfa_pkg::t_axes o_pop_item
);
    import chfa_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    t_axes         r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic          push_ok;
    logic          pop_ok;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_valid    = (r_cnt != '0);
    assign o_pop_item = r_mem[r_rd];
    assign push_ok    = i_push && !o_full;
    assign pop_ok     = i_pop && o_valid;
    assign n_wr       = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd       = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= n_wr;
            end
            if (pop_ok) begin
                r_rd <= n_rd;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");
    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_ok && !pop_ok |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count missed a push");
    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_ok && !push_ok |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("queue count missed a pop");
`endif

endmodule

// ----- sv/chfa_front.sv -----
// front end: sign extension and axis role mapping to north and west
module chfa_front #(
    parameter int SAMPLE_BITS = chfa_pkg::DEF_SAMPLE_BITS
) (
    chfa_in_if.sink          i_in,
    input  chfa_pkg::t_roles i_roles,
    input  logic             i_full,
    output logic             o_push,
    output chfa_pkg::t_axes  o_item
);
    import chfa_pkg::*;

    logic signed [SAMPLE_BITS-1:0] s_x;
    logic signed [SAMPLE_BITS-1:0] s_y;
    logic signed [SAMPLE_BITS-1:0] s_z;
    t_val                          ax [3];
    logic [ROLE_W-1:0]             rl [3];

    assign s_x = i_in.field_x[SAMPLE_BITS-1:0];
    assign s_y = i_in.field_y[SAMPLE_BITS-1:0];
    assign s_z = i_in.field_z[SAMPLE_BITS-1:0];

    // applied z first, then y, then x so later axes win
    assign ax[0] = t_val'(s_z);
    assign ax[1] = t_val'(s_y);
    assign ax[2] = t_val'(s_x);
    assign rl[0] = i_roles.z;
    assign rl[1] = i_roles.y;
    assign rl[2] = i_roles.x;

    always_comb begin
        t_val north;
        t_val west;
        logic has_n;
        logic has_w;
        north = '0;
        west  = '0;
        has_n = 1'b0;
        has_w = 1'b0;
        for (int k = 0; k < 3; k++) begin
            unique case (rl[k])
                ROLE_NORTH: begin
                    north = ax[k];
                    has_n = 1'b1;
                end
                ROLE_SOUTH: begin
                    north = -ax[k];
                    has_n = 1'b1;
                end
                ROLE_WEST: begin
                    west  = ax[k];
                    has_w = 1'b1;
                end
                ROLE_EAST: begin
                    west  = -ax[k];
                    has_w = 1'b1;
                end
                default: begin
                end
            endcase
        end
        o_item.north = north;
        o_item.west  = west;
        o_item.fault = !(has_n && has_w);
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

endmodule

// ----- sv/chfa_back.sv -----
// back end: unrolled vectoring cordic, declination add, wrap and rounding
module chfa_back #(
    parameter int CORDIC_STEPS = chfa_pkg::DEF_CORDIC_STEPS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  chfa_pkg::t_decl i_decl,
    input  logic            i_q_valid,
    input  chfa_pkg::t_axes i_q_item,
    output logic            o_q_pop,
    chfa_out_if.source      o_out
);
    import chfa_pkg::*;

    localparam int N      = CORDIC_STEPS;
    localparam int PROD_W = ANG_W + 1 + 16;
    localparam int SUM_W  = PROD_W + 1;
    localparam int HI_W   = SUM_W - ANG_W;
    localparam logic signed [15:0] TURN_K = 16'(FULL_TURN);

    logic     r_out_valid;
    t_heading r_head;
    logic     r_fault;

    logic en;
    t_xy  r_x   [N+1];
    t_xy  r_y   [N+1];
    t_ang r_z   [N+1];
    logic r_flt [N+1];
    logic r_vld [N+1];

    t_xy x0;
    t_xy y0;

    // whole pipeline moves while the output register is free or drained
    assign en      = !r_out_valid || o_out.ready;
    assign o_q_pop = en && i_q_valid;

    assign x0 = t_xy'(i_q_item.north) <<< PRESCALE_SH;
    assign y0 = t_xy'(i_q_item.west) <<< PRESCALE_SH;

    // left half plane: rotate by half a turn first
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (i_q_item.north[VAL_W-1]) begin
                r_x[0] <= -x0;
                r_y[0] <= -y0;
                r_z[0] <= {1'b1, {(ANG_W-1){1'b0}}};
            end else begin
                r_x[0] <= x0;
                r_y[0] <= y0;
                r_z[0] <= '0;
            end
            r_flt[0] <= i_q_item.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_q_valid;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        t_xy  dx;
        t_xy  dy;
        logic y_neg;
        logic y_pos;

        assign dx    = r_x[i] >>> i;
        assign dy    = r_y[i] >>> i;
        assign y_neg = r_y[i][XY_W-1];
        assign y_pos = !y_neg && (r_y[i] != '0);

        always_ff @(posedge i_clk) begin
            if (en) begin
                priority if (y_pos) begin
                    r_x[i+1] <= r_x[i] + dy;
                    r_y[i+1] <= r_y[i] - dx;
                    r_z[i+1] <= r_z[i] + ATAN_TAB[i];
                end else if (y_neg) begin
                    r_x[i+1] <= r_x[i] - dy;
                    r_y[i+1] <= r_y[i] + dx;
                    r_z[i+1] <= r_z[i] - ATAN_TAB[i];
                end else begin
                    r_x[i+1] <= r_x[i];
                    r_y[i+1] <= r_y[i];
                    r_z[i+1] <= r_z[i];
                end
                r_flt[i+1] <= r_flt[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (en) begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    // binary angle to signed, exactly half a turn stays positive
    logic signed [ANG_W:0]    ang;
    logic signed [PROD_W-1:0] prod;
    logic signed [17:0]       offs;

    assign ang  = {r_z[N][ANG_W-1] & (|r_z[N][ANG_W-2:0]), r_z[N]};
    assign prod = ang * TURN_K;
    assign offs = 18'(i_decl) + 18'(QUARTER_TURN);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pf;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_sv;
    logic                     r_sf;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= prod;
            r_pf   <= r_flt[N];
            r_sum  <= SUM_W'(r_prod) + (SUM_W'(offs) <<< ANG_W);
            r_sf   <= r_pf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_sv <= 1'b0;
        end else if (en) begin
            r_pv <= r_vld[N];
            r_sv <= r_pv;
        end
    end

    // rounding commutes with a whole-turn wrap, so round then adjust
    logic signed [HI_W-1:0] hi;
    logic signed [HI_W-1:0] rnd;
    logic signed [HI_W-1:0] adj;
    logic                   over;

    assign hi   = r_sum[SUM_W-1:ANG_W];
    assign rnd  = hi + HI_W'(r_sum[ANG_W-1]);
    assign over = (hi > HI_W'(FULL_TURN))
               || ((hi == HI_W'(FULL_TURN)) && (|r_sum[ANG_W-1:0]));

    always_comb begin
        priority if (r_sum[SUM_W-1]) begin
            adj = HI_W'(FULL_TURN);
        end else if (over) begin
            adj = -HI_W'(FULL_TURN);
        end else begin
            adj = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_head  <= HEAD_W'(rnd + adj);
            r_fault <= r_sf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_sv;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.heading           = r_head;
    assign o_out.orientation_fault = r_fault;

`ifndef NO_ASSERTIONS
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_head <= HEAD_W'(FULL_TURN))
        else $error("heading beyond a full turn");
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_sv))
        else $error("result appeared without an item in the last stage");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[N]) && $stable(r_sv) && $stable(r_pv))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- sv/compass_heading_from_axes_top.sv -----
// Compass heading from a three-axis magnetometer sample. Each accepted item
// gives one heading in 1/64 degree (0 to 23040) and a fault bit set when no
// axis is mapped to north or none to west. One item is accepted per clock
// while the queue has room, and one result leaves per clock when the
// output is taken; each result passes through the pre-rotation stage, the
// unrolled cordic pipeline (one stage per step) and the scaling,
// declination and wrap stages. A two-entry queue sits between the axis
// mapping and the pipeline. Register writes are taken every cycle and
// must only happen while no item is in flight.
module compass_heading_from_axes_top #(
    parameter int CORDIC_STEPS = chfa_pkg::DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = chfa_pkg::DEF_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chfa_in_if.sink    i_in,
    chfa_out_if.source o_out,
    chfa_cfg_if.sink   i_cfg
);
    import chfa_pkg::*;

    t_decl  r_decl;
    t_roles r_roles;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl    <= DECL_W'(DECL_RESET);
            r_roles.x <= ROLE_NORTH;
            r_roles.y <= ROLE_WEST;
            r_roles.z <= ROLE_UP;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DECLINATION: r_decl    <= i_cfg.data;
                CFG_X_ROLE:      r_roles.x <= i_cfg.data[ROLE_W-1:0];
                CFG_Y_ROLE:      r_roles.y <= i_cfg.data[ROLE_W-1:0];
                CFG_Z_ROLE:      r_roles.z <= i_cfg.data[ROLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic  push;
    logic  full;
    t_axes push_item;
    logic  q_valid;
    logic  q_pop;
    t_axes q_item;

    chfa_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_in    (i_in),
        .i_roles (r_roles),
        .i_full  (full),
        .o_push  (push),
        .o_item  (push_item)
    );

    chfa_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .o_full      (full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_pop_item  (q_item)
    );

    chfa_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_decl    (r_decl),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- tb/chfa_heading_checker.sv -----
// heading checker: watches the three channels, predicts each heading and compares it
`timescale 1ns / 100ps

module chfa_heading_checker
    import chfa_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    chfa_in_if   i_smp,
    chfa_out_if  i_head,
    chfa_cfg_if  i_cfg,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_checked
);

    localparam longint HALF_ANG = 64'sh0000_0000_8000_0000;
    localparam longint FULL_ANG = 64'sh0000_0001_0000_0000;

    typedef struct packed {
        t_heading heading;
        logic     fault;
    } t_heading_exp;

    t_decl        decl;
    t_roles       roles;
    t_heading_exp heading_exp_q[$];
    int           fail_total;
    int           checked_total;

    // keep the low SAMPLE_BITS bits, sign extended
    function automatic int trim_sample(input t_sample s);
        int v;
        v = int'(s);
        v = v <<< (32 - SAMPLE_BITS);
        v = v >>> (32 - SAMPLE_BITS);
        return v;
    endfunction

    function automatic void map_axis(input logic [ROLE_W-1:0] role, input int v,
                                     inout int north, inout int west,
                                     inout bit has_n, inout bit has_w);
        case (role)
            ROLE_NORTH: begin
                north = v;
                has_n = 1'b1;
            end
            ROLE_SOUTH: begin
                north = -v;
                has_n = 1'b1;
            end
            ROLE_WEST: begin
                west  = v;
                has_w = 1'b1;
            end
            ROLE_EAST: begin
                west  = -v;
                has_w = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_heading_exp predict_heading(input t_sample fx, input t_sample fy,
                                                     input t_sample fz);
        int           north;
        int           west;
        bit           has_n;
        bit           has_w;
        longint       cx;
        longint       cy;
        longint       dx;
        longint       dy;
        longint       ang;
        longint       sum;
        longint       rnd;
        t_ang         z;
        int           i;
        t_heading_exp res;
        north = 0;
        west  = 0;
        has_n = 1'b0;
        has_w = 1'b0;
        // later axes override earlier ones
        map_axis(roles.z, trim_sample(fz), north, west, has_n, has_w);
        map_axis(roles.y, trim_sample(fy), north, west, has_n, has_w);
        map_axis(roles.x, trim_sample(fx), north, west, has_n, has_w);

        if (north == 0 && west == 0) begin
            ang = 0;
        end else begin
            cx = longint'(north) * 65536;
            cy = longint'(west) * 65536;
            z  = '0;
            // pre-rotate into the right half plane
            if (cx < 0) begin
                cx = -cx;
                cy = -cy;
                z  = 32'h8000_0000;
            end
            for (i = 0; i < CORDIC_STEPS && i < MAX_CORDIC_STEPS; i++) begin
                dx = cx >>> i;
                dy = cy >>> i;
                if (cy > 0) begin
                    cx = cx + dy;
                    cy = cy - dx;
                    z  = z + ATAN_TAB[i];
                end else if (cy < 0) begin
                    cx = cx - dy;
                    cy = cy + dx;
                    z  = z - ATAN_TAB[i];
                end
            end
            ang = longint'(z);
            if (ang > HALF_ANG) ang = ang - FULL_ANG;
        end

        sum = ang * FULL_TURN + longint'(int'(decl) + QUARTER_TURN) * FULL_ANG;
        if (sum < 0) sum = sum + longint'(FULL_TURN) * FULL_ANG;
        else if (sum > longint'(FULL_TURN) * FULL_ANG) sum = sum - longint'(FULL_TURN) * FULL_ANG;

        rnd         = sum + HALF_ANG;
        res.heading = rnd[32 +: HEAD_W];
        res.fault   = !(has_n && has_w);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_heading_exp got;
        t_heading_exp want;
        if (!i_rst_n) begin
            decl          <= t_decl'(DECL_RESET);
            roles         <= '{x: ROLE_NORTH, y: ROLE_WEST, z: ROLE_UP};
            heading_exp_q.delete();
            fail_total    = 0;
            checked_total = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_DECLINATION: decl    <= t_decl'(i_cfg.data);
                    CFG_X_ROLE:      roles.x <= i_cfg.data[ROLE_W-1:0];
                    CFG_Y_ROLE:      roles.y <= i_cfg.data[ROLE_W-1:0];
                    CFG_Z_ROLE:      roles.z <= i_cfg.data[ROLE_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing so a stray result never meets a fresh item
            if (i_head.valid && i_head.ready) begin
                got.heading = i_head.heading;
                got.fault   = i_head.orientation_fault;
                if (heading_exp_q.size() == 0) begin
                    $display("%0t: unexpected heading %0d fault %0b, nothing pending",
                             $time, got.heading, got.fault);
                    fail_total++;
                end else begin
                    want = heading_exp_q.pop_front();
                    checked_total++;
                    if (got.heading !== want.heading) begin
                        $display("%0t: heading expected %0d actual %0d",
                                 $time, want.heading, got.heading);
                        fail_total++;
                    end
                    if (got.fault !== want.fault) begin
                        $display("%0t: orientation_fault expected %0b actual %0b",
                                 $time, want.fault, got.fault);
                        fail_total++;
                    end
                end
            end
            if (i_smp.valid && i_smp.ready)
                heading_exp_q.push_back(predict_heading(i_smp.field_x, i_smp.field_y,
                                                        i_smp.field_z));
        end
        o_pending    <= heading_exp_q.size();
        o_fail_count <= fail_total;
        o_checked    <= checked_total;
    end

endmodule

// ----- tb/compass_heading_from_axes_top_tb.sv -----
// testbench top: clock, reset, sample and register stimulus, output stalls and verdict
`timescale 1ns / 100ps

module compass_heading_from_axes_top_tb;
    import chfa_pkg::*;

    localparam int CORDIC_STEPS    = DEF_CORDIC_STEPS;
    localparam int SAMPLE_BITS     = DEF_SAMPLE_BITS;
    localparam int LATENCY         = CORDIC_STEPS + 4;
    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 5;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 100;

    // role codes past down, ignored like up and down
    localparam logic [ROLE_W-1:0] ROLE_SPARE_LO = 3'd6;
    localparam logic [ROLE_W-1:0] ROLE_SPARE_HI = 3'd7;

    localparam t_sample S_MAX = 16'sh7FFF;
    localparam t_sample S_MIN = 16'sh8000;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   fail_count;
    int   checked;
    int   idle_cycles;
    int   n_sent;
    int   n_settings;
    bit   burst;

    chfa_in_if  smp_ch ();
    chfa_out_if head_ch ();
    chfa_cfg_if cfg_ch ();

    compass_heading_from_axes_top #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (smp_ch),
        .o_out  (head_ch),
        .i_cfg  (cfg_ch)
    );

    chfa_heading_checker #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (smp_ch),
        .i_head      (head_ch),
        .i_cfg       (cfg_ch),
        .o_pending   (pending),
        .o_fail_count(fail_count),
        .o_checked   (checked)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic t_sample rand_field();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return t_sample'($urandom);
        if (r < 8) return t_sample'(int'($urandom_range(0, 64)) - 32);
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return t_sample'(-1);
            default: return t_sample'(0);
        endcase
    endfunction

    // role in the low bits, junk above it
    function automatic logic [DECL_W-1:0] role_word(input logic [ROLE_W-1:0] role);
        logic [DECL_W-1:0] w;
        w = DECL_W'($urandom);
        w[ROLE_W-1:0] = role;
        return w;
    endfunction

    task automatic send_sample(input t_sample x, input t_sample y, input t_sample z);
        int gap;
        gap = 0;
        if (!burst && $urandom_range(0, 1) == 0) gap = pick_pause();
        if (gap > 0) begin
            smp_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_ch.valid   <= 1'b1;
        smp_ch.field_x <= x;
        smp_ch.field_y <= y;
        smp_ch.field_z <= z;
        @(posedge i_clk);
        while (!smp_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // hold off samples until every heading has come back
    task automatic wait_drained();
        smp_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DECL_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_decl decl, input logic [ROLE_W-1:0] xr,
                                 input logic [ROLE_W-1:0] yr, input logic [ROLE_W-1:0] zr);
        wait_drained();
        write_reg(CFG_DECLINATION, decl);
        write_reg(CFG_X_ROLE, role_word(xr));
        write_reg(CFG_Y_ROLE, role_word(yr));
        write_reg(CFG_Z_ROLE, role_word(zr));
        cfg_ch.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic apply_random_setting();
        t_decl             decl;
        logic [ROLE_W-1:0] role3[3];
        int                na;
        int                wa;
        int                r;
        r = $urandom_range(0, 9);
        if (r == 0) decl = t_decl'($urandom);
        else if (r == 1) decl = ($urandom_range(0, 1) != 0) ? t_decl'(11520) : t_decl'(-11520);
        else decl = t_decl'(int'($urandom_range(0, 23040)) - 11520);
        for (int a = 0; a < 3; a++) role3[a] = ROLE_W'($urandom_range(0, 7));
        // mostly a usable mapping with one north and one west axis
        if ($urandom_range(0, 3) != 0) begin
            na = $urandom_range(0, 2);
            wa = (na + $urandom_range(1, 2)) % 3;
            role3[na] = ($urandom_range(0, 1) != 0) ? ROLE_NORTH : ROLE_SOUTH;
            role3[wa] = ($urandom_range(0, 1) != 0) ? ROLE_WEST : ROLE_EAST;
        end
        apply_setting(decl, role3[0], role3[1], role3[2]);
    endtask

    initial begin : head_sink
        int hold;
        hold = 0;
        head_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold = hold - 1;
            end else if (burst || $urandom_range(0, 2) != 0) begin
                head_ch.ready <= 1'b1;
                hold = $urandom_range(0, 12);
            end else begin
                head_ch.ready <= 1'b0;
                hold = pick_pause() - 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((smp_ch.valid && smp_ch.ready) || (head_ch.valid && head_ch.ready) ||
                     (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d headings pending",
                         $time, WATCHDOG_LIMIT, pending);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        i_rst_n        = 1'b0;
        smp_ch.valid   = 1'b0;
        smp_ch.field_x = '0;
        smp_ch.field_y = '0;
        smp_ch.field_z = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_DECLINATION;
        cfg_ch.data    = '0;
        burst          = 1'b0;
        n_sent         = 0;
        n_settings     = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // settings after reset: x north, y west, z up
        send_sample(0, 0, 0);
        send_sample(S_MAX, 0, 0);
        send_sample(S_MIN, 0, 0);
        send_sample(-1, 0, 123);
        send_sample(0, S_MAX, S_MIN);
        send_sample(0, S_MIN, S_MAX);
        send_sample(S_MAX, S_MAX, S_MAX);
        send_sample(S_MIN, S_MIN, S_MIN);
        send_sample(S_MIN, S_MAX, 0);
        send_sample(1, -1, 0);

        // half a turn of declination, south and east axes
        apply_setting(11520, ROLE_SOUTH, ROLE_EAST, ROLE_UP);
        send_sample(S_MAX, S_MIN, 5);
        send_sample(S_MIN, 0, 0);
        send_sample(0, S_MIN, 0);
        send_sample(100, 100, -100);

        // no west axis
        apply_setting(-11520, ROLE_DOWN, ROLE_SPARE_LO, ROLE_NORTH);
        send_sample(5, 5, S_MIN);
        send_sample(0, 0, 0);

        // no axis used at all, most negative declination
        apply_setting(-16384, ROLE_SPARE_HI, ROLE_UP, ROLE_DOWN);
        send_sample(S_MAX, -1, S_MIN);

        // x east overrides z west, most positive declination
        apply_setting(16383, ROLE_EAST, ROLE_NORTH, ROLE_WEST);
        send_sample(S_MIN, S_MAX, 1234);
        send_sample(S_MAX, S_MIN, -1);

        // x west overrides y west, north from a south z axis
        apply_setting(0, ROLE_WEST, ROLE_WEST, ROLE_SOUTH);
        send_sample(200, -300, S_MAX);
        send_sample(0, 0, S_MIN);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_random_setting();
            burst = (ph % 3 == 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_sample(rand_field(), rand_field(), rand_field());
                if ($urandom_range(0, 99) == 0) wait_drained();
            end
        end
        burst = 1'b0;

        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        $display("covered %0d samples over %0d register settings after reset, %0d headings checked",
                 n_sent, n_settings, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
